### rtl/core/jti_pkg.sv
package jti_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int NUM_JOINTS_DEF  = 7;

   localparam int TIME_W  = 32;
   localparam int VALUE_W = 32;
   localparam int WEIGHT_W = 16;

   // item codes
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;
   localparam logic [1:0] ACT_NOP   = 2'd3;

   // command passed from front to back
   typedef struct packed {
      logic        is_query;
      logic [1:0]  act;
      logic [31:0] sample_time;
      logic [3:0]  joint;
      logic [31:0] position;
      logic [31:0] velocity;
   } cmd_type;

endpackage

### rtl/core/jti_front.sv
module jti_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_act,
   input  logic [31:0]       in_time,
   input  logic [2:0]        in_joint,
   input  logic [31:0]       in_pos,
   input  logic [31:0]       in_vel,
   output logic              q_valid,
   input  logic              q_ready,
   output jti_pkg::cmd_type  q_cmd
);
   import jti_pkg::*;

   // two entry queue between front and back
   cmd_type   slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic      wp_ff, wp_in, rp_ff, rp_in;
   cmd_type   cmd;
   logic      push, pop;

   // classify the item
   always_comb begin
      cmd.act         = in_act;
      cmd.is_query    = (in_act == ACT_QUERY);
      cmd.sample_time = in_time;
      cmd.joint       = {1'b0, in_joint};
      cmd.position    = in_pos;
      cmd.velocity    = in_vel;
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready && (in_act != ACT_NOP);
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_cmd    = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (push) slot_ff[wp_ff] <= cmd;
   end
endmodule

### rtl/core/jti_divider.sv
module jti_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] numer,
   input  logic [31:0] denom,
   output logic        done,
   output logic [15:0] quot
);
   import jti_pkg::*;

   // restoring division of numer<<16 by denom, one quotient bit a cycle
   logic [32:0] rem_ff, rem_in;
   logic [15:0] q_ff, q_in;
   logic [31:0] d_ff;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [33:0] trial;

   assign trial = {rem_ff, 1'b0} - {2'b0, d_ff};

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = {1'b0, numer};
         q_in    = '0;
         cnt_in  = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            q_in   = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], 1'b0};
            q_in   = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (start) d_ff <= denom;
   end

   assign done = busy_ff && (cnt_ff == 5'd1);
   assign quot = q_in;
endmodule

### rtl/core/jti_back.sv
module jti_back #(
   parameter int TABLE_DEPTH = jti_pkg::TABLE_DEPTH_DEF,
   parameter int NUM_JOINTS  = jti_pkg::NUM_JOINTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  jti_pkg::cmd_type  q_cmd,
   input  logic              vel_en,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [2:0]        out_joint,
   output logic [31:0]       out_pos,
   output logic [31:0]       out_vel,
   output logic              out_last,
   output logic              out_empty
);
   import jti_pkg::*;

   localparam int RW  = $clog2(TABLE_DEPTH);
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int JW  = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int VD  = TABLE_DEPTH * NUM_JOINTS;
   localparam int VW  = $clog2(VD);

   typedef enum logic [3:0] {
      S_IDLE, S_T0, S_TL, S_CHK, S_SRCH, S_SRCHW, S_HI, S_DIVW,
      S_RD0, S_RD1, S_MUL, S_SUM, S_OUT
   } state_type;

   // memories
   logic [31:0] time_mem [TABLE_DEPTH];
   logic [31:0] pos_mem  [VD];
   logic [31:0] vel_mem  [VD];

   state_type   st_ff;
   logic [CW-1:0] rows_ff;
   logic [31:0] t_ff, tr_ff, tlo_ff, thi_ff;
   logic [RW-1:0] ta_ff, lo_ff, hi_ff;
   logic [VW-1:0] va_ff;
   logic [31:0] pr_ff, vr_ff, p0_ff, v0_ff;
   logic [15:0] a_ff;
   logic [1:0]  mode_ff;
   logic [JW-1:0] j_ff;
   logic        sel_hi_ff;
   logic signed [48:0] mp0_ff, mp1_ff, mv0_ff, mv1_ff;
   logic        ov_ff;
   logic [2:0]  oj_ff;
   logic [31:0] op_ff, ovl_ff;
   logic        ol_ff, oe_ff;
   logic        dstart;
   logic        ddone;
   logic [15:0] dq;
   logic        is_load, ld_ok;
   logic        emit;
   logic [RW-1:0] mid;
   logic [RW:0] span;

   jti_divider u_div (
      .clock(clock), .reset(reset), .start(dstart),
      .numer(t_ff - tlo_ff), .denom(thi_ff - tlo_ff),
      .done(ddone), .quot(dq)
   );

   assign q_ready  = (st_ff == S_IDLE) && !ov_ff;
   assign is_load  = q_valid && q_ready && (q_cmd.act == ACT_LOAD);
   assign ld_ok    = is_load && (rows_ff < CW'(TABLE_DEPTH))
                     && (q_cmd.joint < 4'(NUM_JOINTS));
   assign span     = {1'b0, hi_ff} - {1'b0, lo_ff};
   assign mid      = lo_ff + span[RW:1];
   // divider starts once both bracketing times are registered
   assign dstart   = (st_ff == S_DIVW) && (mp0_ff == 49'sd2) && (thi_ff != tlo_ff);
   assign emit     = (st_ff == S_SUM) && (!ov_ff || out_ready);

   // memory writes and registered reads
   always_ff @(posedge clock) begin
      if (ld_ok) begin
         pos_mem[VW'(rows_ff[RW-1:0] * NUM_JOINTS + int'(q_cmd.joint))] <= q_cmd.position;
         vel_mem[VW'(rows_ff[RW-1:0] * NUM_JOINTS + int'(q_cmd.joint))] <= q_cmd.velocity;
         if (q_cmd.joint == 4'(NUM_JOINTS - 1)) time_mem[rows_ff[RW-1:0]] <= q_cmd.sample_time;
      end
      tr_ff <= time_mem[ta_ff];
      pr_ff <= pos_mem[va_ff];
      vr_ff <= vel_mem[va_ff];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         rows_ff <= '0;
         ov_ff   <= 1'b0;
      end else begin
         if (emit) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: begin
               if (q_valid && q_ready) begin
                  if (q_cmd.act == ACT_CLEAR) rows_ff <= '0;
                  if (ld_ok && q_cmd.joint == 4'(NUM_JOINTS - 1)) rows_ff <= rows_ff + 1'b1;
                  if (q_cmd.is_query) begin
                     t_ff  <= q_cmd.sample_time;
                     j_ff  <= '0;
                     a_ff  <= '0;
                     if (rows_ff == '0) begin
                        mode_ff <= 2'd0;
                        st_ff   <= S_RD0;
                     end else begin
                        ta_ff <= '0;
                        st_ff <= S_T0;
                     end
                  end
               end
            end
            S_T0: begin
               ta_ff <= RW'(rows_ff - 1'b1);
               st_ff <= S_TL;
            end
            S_TL: begin
               tlo_ff <= tr_ff;
               st_ff  <= S_CHK;
            end
            S_CHK: begin
               if (t_ff <= tlo_ff) begin
                  mode_ff <= 2'd1; lo_ff <= '0; st_ff <= S_RD0;
               end else if (t_ff >= tr_ff) begin
                  mode_ff <= 2'd1; lo_ff <= RW'(rows_ff - 1'b1); st_ff <= S_RD0;
               end else begin
                  mode_ff <= 2'd2; lo_ff <= '0; hi_ff <= RW'(rows_ff - 1'b1);
                  st_ff <= S_SRCH;
               end
            end
            S_SRCH: begin
               if (span > 1) begin
                  ta_ff <= mid;
                  st_ff <= S_SRCHW;
                  sel_hi_ff <= 1'b0;
               end else begin
                  ta_ff <= lo_ff;
                  st_ff <= S_HI;
                  sel_hi_ff <= 1'b0;
               end
            end
            S_SRCHW: begin
               // ta_ff is set in S_SRCH; tr_ff is registered while sel_hi_ff is low and compared once it is high
               if (sel_hi_ff) begin
                  if (tr_ff <= t_ff) lo_ff <= ta_ff; else hi_ff <= ta_ff;
                  sel_hi_ff <= 1'b0;
                  st_ff <= S_SRCH;
               end else begin
                  sel_hi_ff <= 1'b1;
               end
            end
            S_HI: begin
               // wait for lo time, then hi time
               if (!sel_hi_ff) begin
                  ta_ff <= hi_ff; sel_hi_ff <= 1'b1;
                  st_ff <= S_DIVW;
                  mp0_ff <= '0;
               end
            end
            S_DIVW: begin
               if (mp0_ff == '0) begin
                  tlo_ff <= tr_ff; mp0_ff <= 49'sd1;
               end else if (mp0_ff == 49'sd1) begin
                  thi_ff <= tr_ff; mp0_ff <= 49'sd2;
               end else if (mp0_ff == 49'sd2) begin
                  if (thi_ff == tlo_ff) begin
                     a_ff <= '0; st_ff <= S_RD0;
                  end else begin
                     mp0_ff <= 49'sd3;
                  end
               end else if (ddone) begin
                  a_ff  <= dq;
                  st_ff <= S_RD0;
               end
            end
            S_RD0: begin
               if (!ov_ff || out_ready) begin
                  va_ff <= VW'(int'(lo_ff) * NUM_JOINTS + int'(j_ff));
                  st_ff <= S_RD1;
                  sel_hi_ff <= 1'b0;
               end
            end
            S_RD1: begin
               if (!sel_hi_ff) begin
                  va_ff <= VW'(int'(hi_ff) * NUM_JOINTS + int'(j_ff));
                  sel_hi_ff <= 1'b1;
               end else begin
                  p0_ff <= pr_ff; v0_ff <= vr_ff;
                  st_ff <= S_MUL;
               end
            end
            S_MUL: begin
               mp0_ff <= $signed(p0_ff) * $signed({1'b0, 17'(17'h10000 - {1'b0, a_ff})});
               mv0_ff <= $signed(v0_ff) * $signed({1'b0, 17'(17'h10000 - {1'b0, a_ff})});
               mp1_ff <= $signed(pr_ff) * $signed({2'b0, a_ff});
               mv1_ff <= $signed(vr_ff) * $signed({2'b0, a_ff});
               st_ff  <= S_SUM;
            end
            S_SUM: begin
               if (emit) begin
                  oj_ff  <= 3'(j_ff);
                  oe_ff  <= (mode_ff == 2'd0);
                  ol_ff  <= (j_ff == JW'(NUM_JOINTS - 1));
                  unique case (mode_ff)
                     2'd0: begin op_ff <= '0; ovl_ff <= '0; end
                     2'd1: begin
                        op_ff  <= p0_ff;
                        ovl_ff <= vel_en ? v0_ff : '0;
                     end
                     default: begin
                        op_ff  <= 32'((mp0_ff + mp1_ff) >>> 16);
                        ovl_ff <= vel_en ? 32'((mv0_ff + mv1_ff) >>> 16) : '0;
                     end
                  endcase
                  if (j_ff == JW'(NUM_JOINTS - 1)) st_ff <= S_IDLE;
                  else begin
                     j_ff  <= j_ff + 1'b1;
                     st_ff <= S_RD0;
                  end
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign out_valid = ov_ff;
   assign out_joint = oj_ff;
   assign out_pos   = op_ff;
   assign out_vel   = ovl_ff;
   assign out_last  = ol_ff;
   assign out_empty = oe_ff;
endmodule

### rtl/core/joint_trajectory_interpolator_top.sv
// joint trajectory interpolator
// req_ channel: one beat is a clear, a load of one joint value, a query, or a no-op.
// loads fill the row being built; the beat for the last joint commits it
// with its sample time. loads into a full table are dropped.
// a query returns one rsp_ beat per joint, joint 0 first, tlast on the
// last one. times outside the table clamp to the first or last row;
// inside, the bracketing pair is found by binary search and blended.
// csr_ channel writes velocities_loaded; write it only while idle.
// a query runs the binary search, the two time reads and the 16-step
// restoring divider, then passes each joint in turn through the shared
// read/multiply path. a clamped query skips search and divide, an empty
// table goes straight to the per-joint path. loads and clears reach the
// table when the back end takes them from the queue, and can follow back
// to back.
// reset empties the table (contents are kept but unreachable) and the queue.
// a stalled rsp_ beat holds; the back end waits and the two-entry queue
// keeps accepting req_ beats until it fills.
module joint_trajectory_interpolator_top #(
   parameter int TABLE_DEPTH = jti_pkg::TABLE_DEPTH_DEF,
   parameter int NUM_JOINTS  = jti_pkg::NUM_JOINTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[1:0], sample_time[33:2], joint_index[36:34],
   // joint_position[68:37], joint_velocity[100:69], zero fill
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_joint[2:0], interp_position[34:3], interp_velocity[66:35], zero fill
   output logic [71:0]  rsp_tdata,
   output logic         rsp_tlast,
   // table_empty[0]
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);
   import jti_pkg::*;

   logic    vel_en_ff;
   logic    q_valid, q_ready;
   cmd_type q_cmd;
   logic [2:0]  oj;
   logic [31:0] op, ov;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) vel_en_ff <= 1'b0;
      else if (csr_valid) vel_en_ff <= csr_data;
   end

   jti_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_act(req_tdata[1:0]), .in_time(req_tdata[33:2]),
      .in_joint(req_tdata[36:34]), .in_pos(req_tdata[68:37]),
      .in_vel(req_tdata[100:69]),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   jti_back #(.TABLE_DEPTH(TABLE_DEPTH), .NUM_JOINTS(NUM_JOINTS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .vel_en(vel_en_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_joint(oj), .out_pos(op), .out_vel(ov),
      .out_last(rsp_tlast), .out_empty(rsp_tuser)
   );

   assign rsp_tdata = {5'b0, ov, op, oj};
endmodule

### dv/jti_checker.sv
`timescale 1ns / 100ps

module jti_checker #(
   parameter int DEPTH  = jti_pkg::TABLE_DEPTH_DEF,
   parameter int JOINTS = jti_pkg::NUM_JOINTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [71:0]  rsp_tdata,
   input  logic         rsp_tlast,
   input  logic         rsp_tuser,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic         csr_data,
   output int           fail_count,
   output int           pending,
   output int           beats_checked
);
   import jti_pkg::*;

   typedef struct {
      logic [2:0]  joint;
      logic [31:0] pos;
      logic [31:0] vel;
      logic        last;
      logic        empty;
   } joint_beat_type;

   // mirror of the trajectory table
   logic [31:0] row_time [DEPTH];
   logic [31:0] row_pos  [DEPTH*JOINTS];
   logic [31:0] row_vel  [DEPTH*JOINTS];
   int unsigned rows;
   logic        vel_on;
   joint_beat_type joint_beats_q[$];

   // linear blend with floor, weight in Q0.16
   function automatic logic [31:0] lerp_q16(logic [31:0] v0, logic [31:0] v1,
                                            longint w);
      longint s;
      s = longint'($signed(v0)) * (65536 - w) + longint'($signed(v1)) * w;
      return 32'(s >>> 16);
   endfunction

   // expected beats for one query time
   task automatic predict_query(logic [31:0] t);
      int unsigned lo, hi, mid, mode;
      longint w;
      longint unsigned n, d;
      joint_beat_type b;
      lo = 0; hi = 0; w = 0; mode = 0;
      if (rows > 0) begin
         if (t <= row_time[0]) begin
            mode = 1; lo = 0;
         end else if (t >= row_time[rows-1]) begin
            mode = 1; lo = rows - 1;
         end else begin
            hi = rows - 1;
            while (hi - lo > 1) begin
               mid = lo + (hi - lo) / 2;
               if (row_time[mid] <= t) lo = mid; else hi = mid;
            end
            d = 32'(row_time[hi] - row_time[lo]);
            n = 32'(t - row_time[lo]);
            w = (d != 0) ? longint'((n << 16) / d) : 0;
            if (w > 65535) w = 65535;
            mode = 2;
         end
      end
      for (int j = 0; j < JOINTS; j++) begin
         b.joint = j[2:0];
         b.pos = '0;
         b.vel = '0;
         if (mode == 1) begin
            b.pos = row_pos[lo*JOINTS+j];
            b.vel = row_vel[lo*JOINTS+j];
         end else if (mode == 2) begin
            b.pos = lerp_q16(row_pos[lo*JOINTS+j], row_pos[hi*JOINTS+j], w);
            b.vel = lerp_q16(row_vel[lo*JOINTS+j], row_vel[hi*JOINTS+j], w);
         end
         if (!vel_on) b.vel = '0;
         b.last  = (j == JOINTS - 1);
         b.empty = (mode == 0);
         joint_beats_q.insert(joint_beats_q.size(), b);
      end
   endtask

   always @(posedge clock) begin
      logic [1:0]  act;
      logic [31:0] t;
      logic [2:0]  jn;
      joint_beat_type exp_b;
      if (reset) begin
         rows = 0;
         vel_on = 1'b0;
         joint_beats_q.delete();
         fail_count <= 0;
         beats_checked <= 0;
      end else begin
         // register write
         if (csr_valid && csr_ready) vel_on = csr_data;

         // request beat
         if (req_tvalid && req_tready) begin
            act = req_tdata[1:0];
            t   = req_tdata[33:2];
            jn  = req_tdata[36:34];
            case (act)
               ACT_CLEAR: rows = 0;
               ACT_LOAD: begin
                  if (rows < DEPTH && jn < JOINTS) begin
                     row_pos[rows*JOINTS+jn] = req_tdata[68:37];
                     row_vel[rows*JOINTS+jn] = req_tdata[100:69];
                     if (jn == JOINTS - 1) begin
                        row_time[rows] = t;
                        rows++;
                     end
                  end
               end
               ACT_QUERY: predict_query(t);
               default: ;
            endcase
         end

         // result beat
         if (rsp_tvalid && rsp_tready) begin
            beats_checked <= beats_checked + 1;
            if (joint_beats_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t unexpected result beat data=%h", $realtime, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               exp_b = joint_beats_q.pop_front();
               if (rsp_tdata[2:0] !== exp_b.joint || rsp_tdata[34:3] !== exp_b.pos ||
                   rsp_tdata[66:35] !== exp_b.vel || rsp_tlast !== exp_b.last ||
                   rsp_tuser !== exp_b.empty) begin
                  if (fail_count < 10)
                     $display({"%0t mismatch exp j=%0d p=%h v=%h l=%b e=%b",
                               " got j=%0d p=%h v=%h l=%b e=%b"},
                              $realtime, exp_b.joint, exp_b.pos, exp_b.vel, exp_b.last,
                              exp_b.empty, rsp_tdata[2:0], rsp_tdata[34:3],
                              rsp_tdata[66:35], rsp_tlast, rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= joint_beats_q.size();
   end

endmodule

### dv/joint_trajectory_interpolator_top_tb.sv
`timescale 1ns / 100ps

module joint_trajectory_interpolator_top_tb;
   import jti_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_data = 1'b0;

   int  fail_count, pending, beats_checked;
   int  quiet_cycles = 0;
   int  items_sent = 0, queries_sent = 0;
   bit  req_gaps = 1'b1, rsp_gaps = 1'b1, hold_rsp = 1'b0;
   logic [31:0] time_now = 32'h0001_0000;

   always #5 clock = ~clock;

   joint_trajectory_interpolator_top dut (.*);

   jti_checker chk (.*);

   // watchdog on lack of progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("joint_trajectory_interpolator_top_tb: errors");
            $finish;
         end
      end
   end

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (rsp_gaps && !reset && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_beat(logic [1:0] act, logic [31:0] t, logic [2:0] jn,
                            logic [31:0] p, logic [31:0] v);
      int n;
      if (req_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         n = $urandom_range(1, 15);
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b0, v, p, jn, t, act};
      do @(posedge clock); while (!req_tready);
      if (act != ACT_NOP && !(act == ACT_LOAD && jn > 6)) items_sent++;
      if (act == ACT_QUERY) queries_sent++;
   endtask

   // one full row, joints in order, optional noise between them
   task automatic load_row(logic [31:0] t, bit noisy);
      for (int j = 0; j < 7; j++) begin
         if (noisy && $urandom_range(0, 9) == 0)
            send_beat(ACT_LOAD, $urandom, 3'd7, $urandom, $urandom);
         // rewrite of the same joint, never the committing one
         if (noisy && j < 6 && $urandom_range(0, 9) == 0)
            send_beat(ACT_LOAD, $urandom, j[2:0], $urandom, $urandom);
         send_beat(ACT_LOAD, t, j[2:0], $urandom, $urandom);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_vel_flag(logic val);
      csr_valid <= 1'b1;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_mix(int target);
      int pick;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            time_now = ($urandom_range(0, 9) == 0) ? $urandom
                       : time_now + $urandom_range(0, 32'h0004_0000);
            load_row(time_now, 1'b1);
         end else if (pick < 85) begin
            send_beat(ACT_QUERY, ($urandom_range(0, 4) == 0) ? $urandom
                      : $urandom_range(0, time_now + 32'h0002_0000), 3'($urandom),
                      $urandom, $urandom);
         end else if (pick < 90) begin
            // row cut short by a clear
            for (int j = 0; j < $urandom_range(1, 5); j++)
               send_beat(ACT_LOAD, $urandom, j[2:0], $urandom, $urandom);
            send_beat(ACT_CLEAR, $urandom, 3'($urandom), $urandom, $urandom);
            time_now = $urandom_range(0, 32'h0010_0000);
         end else if (pick < 94) begin
            send_beat(ACT_CLEAR, $urandom, 3'($urandom), $urandom, $urandom);
         end else begin
            send_beat(ACT_NOP, $urandom, 3'($urandom), $urandom, $urandom);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_vel_flag(1'b1);

      // directed: empty table, noise beats, two rows of extreme values
      send_beat(ACT_QUERY, 32'h0, 3'd0, 32'h0, 32'h0);
      send_beat(ACT_NOP, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(ACT_LOAD, 32'h0001_0000, 3'd7, 32'h1, 32'h1);
      for (int j = 0; j < 7; j++)
         send_beat(ACT_LOAD, 32'h0001_0000, j[2:0], 32'h7FFF_FFFF, 32'h8000_0000);
      send_beat(ACT_QUERY, 32'h0001_8000, 3'd0, 32'h0, 32'h0);
      for (int j = 0; j < 7; j++)
         send_beat(ACT_LOAD, 32'h0003_0000, j[2:0], 32'h8000_0000, 32'h7FFF_FFFF);
      send_beat(ACT_QUERY, 32'h0000_0000, 3'd0, 32'h0, 32'h0);
      send_beat(ACT_QUERY, 32'h0001_0000, 3'd0, 32'h0, 32'h0);
      send_beat(ACT_QUERY, 32'h0002_0000, 3'd0, 32'h0, 32'h0);
      send_beat(ACT_QUERY, 32'h0002_FFFF, 3'd0, 32'h0, 32'h0);
      send_beat(ACT_QUERY, 32'hFFFF_FFFF, 3'd0, 32'h0, 32'h0);
      send_beat(ACT_CLEAR, 32'h0, 3'd0, 32'h0, 32'h0);
      send_beat(ACT_QUERY, 32'h0002_0000, 3'd0, 32'h0, 32'h0);
      time_now = 32'h0001_0000;

      // random part with gaps on both sides
      random_mix(60);

      // long hold-off on results while queries keep coming
      hold_rsp = 1'b1;
      for (int q = 0; q < 8; q++)
         send_beat(ACT_QUERY, $urandom_range(0, time_now), 3'($urandom), $urandom,
                   $urandom);
      wait_idle();
      write_vel_flag(1'b0);
      random_mix(95);
      wait_idle();
      write_vel_flag(1'b1);

      // last part without gaps: a fresh row and queries back to back
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      send_beat(ACT_CLEAR, 32'h0, 3'd0, 32'h0, 32'h0);
      time_now = 32'h0000_8000;
      load_row(time_now, 1'b0);
      for (int q = 0; q < 3; q++)
         send_beat(ACT_QUERY, $urandom_range(0, time_now + 32'h0001_0000), 3'($urandom),
                   $urandom, $urandom);
      send_beat(ACT_QUERY, 32'hFFFF_FFFF, 3'd0, 32'h0, 32'h0);

      wait_idle();
      $display("run covered %0d counted items including %0d queries", items_sent,
               queries_sent);
      $display("%0d result beats checked across clamp, blend and empty-table cases",
               beats_checked);
      if (fail_count == 0)
         $display("joint_trajectory_interpolator_top_tb: clean");
      else
         $display("joint_trajectory_interpolator_top_tb: errors");
      $finish;
   end

endmodule

### joint_trajectory_interpolator_top.f
rtl/core/jti_pkg.sv
rtl/core/jti_front.sv
rtl/core/jti_divider.sv
rtl/core/jti_back.sv
rtl/core/joint_trajectory_interpolator_top.sv
dv/jti_checker.sv
dv/joint_trajectory_interpolator_top_tb.sv
